// ===== design/amx_pkg.sv =====
package amx_pkg;

    // stream payload layout
    localparam int FIELD_BITS    = 32;
    localparam int IN_FIELDS     = 12;
    localparam int IN_DATA_BITS  = FIELD_BITS * IN_FIELDS;
    localparam int OUT_DATA_BITS = 104;
    localparam int USER_BITS     = 2;

    // row slot of a beat inside one matrix
    typedef logic [1:0] slot_t;

    localparam slot_t SLOT_ROW0  = 2'd0;
    localparam slot_t SLOT_ROW1  = 2'd1;
    localparam slot_t SLOT_ROW2  = 2'd2;
    localparam slot_t SLOT_XLATE = 2'd3;

    // control that travels with every beat through the back end
    typedef struct packed {
        logic  valid;
        slot_t slot;
        logic  singular;
    } beat_ctrl_t;

endpackage

// ===== design/affine_matrix_inverse_core.sv =====
// a matrix passes the front-end stages, the divider and the post stages; its first row beat
//   leads, and the other three rows follow one per cycle while the output is not stalled
// each matrix takes four row beats on the output channel; the divider and the post stages
//   take a new beat every cycle unless the output stalls
// reset: rst_n clears every valid bit and the row counter, no memory to clear
module affine_matrix_inverse_core
    import amx_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // input beat, tdata from bit 0 up: row1_col1, row1_col2, row1_col3, row2_col1,
    // row2_col2, row2_col3, row3_col1, row3_col2, row3_col3, shift_x, shift_y, shift_z
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // result beat, tdata from bit 0 up: row_number, value_first, value_second,
    // value_third, zero padding
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    // tuser from bit 0 up: singular, saturated
    output logic [USER_BITS-1:0]     m_tuser,
    // tlast marks the translation row
    output logic                     m_tlast
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 2;
    localparam int NW = CW + 2 * F;
    // wide enough for the scaled cofactor and for the determinant shifted by W
    localparam int EW = (NW > DW + W) ? NW : DW + W;

    // front end: operands, cofactor products, cofactors, determinant
    logic                hold_valid;
    logic                hold_drop;
    logic signed [CW-1:0] cof [9];
    logic signed [DW-1:0] det;
    logic signed [W-1:0]  shift [3];

    // row sequencer feeding the divider
    slot_t               slot_reg;
    logic                adv;
    logic                issue;
    logic                det_neg;
    logic [DW-1:0]       det_mag;
    logic signed [CW-1:0] row_cof [3];
    logic [CW-1:0]       cof_mag [3];
    logic signed [W-1:0] row_shift;
    beat_ctrl_t          iss_ctrl;
    logic [EW-1:0]       iss_num [3];
    logic [EW-1:0]       iss_den;
    logic [2:0]          iss_neg;

    // divider to post stages
    beat_ctrl_t          div_ctrl;
    logic [W:0]          div_quo [3];
    logic [2:0]          div_neg;
    logic signed [W-1:0] div_shift;

    // output fields
    slot_t                 o_row;
    logic [FIELD_BITS-1:0] o_value [3];
    logic                  o_singular;
    logic                  o_saturated;
    logic                  o_last;

    amx_front #(
        .W (W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .hold_valid (hold_valid),
        .hold_drop  (hold_drop),
        .cof        (cof),
        .det        (det),
        .shift      (shift)
    );

    // the held matrix issues rows 0..2 to the divider and then a translation slot;
    // it is released as the translation slot leaves
    assign issue     = adv && hold_valid;
    assign hold_drop = issue && (slot_reg == SLOT_XLATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= SLOT_ROW0;
        end
        else if (issue)
        begin
            slot_reg <= slot_t'(slot_reg + 1'b1);
        end
    end

    always_comb
    begin
        case (slot_reg)
            SLOT_ROW0:
            begin
                row_cof   = cof[0:2];
                row_shift = shift[0];
            end
            SLOT_ROW1:
            begin
                row_cof   = cof[3:5];
                row_shift = shift[1];
            end
            SLOT_ROW2:
            begin
                row_cof   = cof[6:8];
                row_shift = shift[2];
            end
            default:
            begin
                // translation slot carries no division
                row_cof   = '{default: '0};
                row_shift = '0;
            end
        endcase
    end

    // magnitudes and signs for the unsigned divider; numerator scaled by 2^(2*F)
    always_comb
    begin
        det_neg = det[DW-1];
        det_mag = det_neg ? DW'(-det) : DW'(det);
        iss_den = EW'(det_mag);
        for (int l = 0; l < 3; l++)
        begin
            cof_mag[l] = row_cof[l][CW-1] ? CW'(-row_cof[l]) : CW'(row_cof[l]);
            iss_num[l] = EW'(cof_mag[l]) << (2 * F);
            iss_neg[l] = row_cof[l][CW-1] ^ det_neg;
        end
        iss_ctrl.valid    = hold_valid;
        iss_ctrl.slot     = slot_reg;
        iss_ctrl.singular = (det == '0);
    end

    amx_div #(
        .W  (W),
        .EW (EW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_ctrl   (iss_ctrl),
        .in_num    (iss_num),
        .in_den    (iss_den),
        .in_neg    (iss_neg),
        .in_shift  (row_shift),
        .out_ctrl  (div_ctrl),
        .out_quo   (div_quo),
        .out_neg   (div_neg),
        .out_shift (div_shift)
    );

    // sign fix-up, saturation, translation accumulate and output register
    amx_post #(
        .W (W),
        .F (F)
    ) u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_ctrl       (div_ctrl),
        .in_quo        (div_quo),
        .in_neg        (div_neg),
        .in_shift      (div_shift),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_row       (o_row),
        .out_value     (o_value),
        .out_singular  (o_singular),
        .out_saturated (o_saturated),
        .out_last      (o_last)
    );

    assign m_tdata = {6'b0, o_value[2], o_value[1], o_value[0], o_row};
    assign m_tuser = {o_saturated, o_singular};
    assign m_tlast = o_last;

    // a singular matrix gives all-zero rows that are never flagged as clipped
    a_singular_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[97:2] == '0) && !m_tuser[1])
        else $error("singular row carries data");

    // the input only stalls while the hold stage is occupied
    a_front_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> hold_valid)
        else $error("input stalled with empty hold stage");

    // a stalled output freezes the row sequencer
    a_seq_freeze : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(slot_reg))
        else $error("row issued during output stall");

endmodule

// ===== design/amx_front.sv =====
module amx_front
    import amx_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [IN_DATA_BITS-1:0] in_data,
    output logic                    hold_valid,
    input  logic                    hold_drop,
    output logic signed [2*W:0]     cof [9],
    output logic signed [3*W+1:0]   det,
    output logic signed [W-1:0]     shift [3]
);

    localparam int MINW = (W < FIELD_BITS) ? W : FIELD_BITS;
    localparam int DW   = 3 * W + 2;
    localparam int CW   = 2 * W + 1;

    logic [4:0] valid_reg;
    logic [4:0] load;

    // stage 0: operands
    logic signed [W-1:0]    a_reg [9];
    logic signed [W-1:0]    sh0_reg [3];
    // stage 1: cofactor products
    logic signed [2*W-1:0]  prod_p_next [9];
    logic signed [2*W-1:0]  prod_q_next [9];
    logic signed [2*W-1:0]  prod_p_reg [9];
    logic signed [2*W-1:0]  prod_q_reg [9];
    logic signed [W-1:0]    top1_reg [3];
    logic signed [W-1:0]    sh1_reg [3];
    // stage 2: cofactors
    logic signed [CW-1:0]   cof2_reg [9];
    logic signed [W-1:0]    top2_reg [3];
    logic signed [W-1:0]    sh2_reg [3];
    // stage 3: determinant partial products
    logic signed [CW-1:0]   lo_next [3];
    logic signed [CW-1:0]   hi_next [3];
    logic signed [CW-1:0]   lo_reg [3];
    logic signed [CW-1:0]   hi_reg [3];
    logic signed [CW-1:0]   cof3_reg [9];
    logic signed [W-1:0]    sh3_reg [3];
    // stage 4: hold stage
    logic signed [DW-1:0]   det_next;
    logic signed [DW-1:0]   det_reg;
    logic signed [CW-1:0]   cof4_reg [9];
    logic signed [W-1:0]    sh4_reg [3];

    // bubble-collapsing stage enables
    always_comb
    begin
        load[4] = !valid_reg[4] || hold_drop;
        for (int k = 3; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign in_ready   = load[0];
    assign hold_valid = valid_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < 5; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_cof_row
        for (genvar j = 0; j < 3; j++)
        begin : g_cof_col
            localparam int RA = (j + 1) % 3;
            localparam int RB = (j + 2) % 3;
            localparam int CA = (i + 1) % 3;
            localparam int CB = (i + 2) % 3;
            assign prod_p_next[i*3+j] = (2*W)'(a_reg[RA*3+CA]) * (2*W)'(a_reg[RB*3+CB]);
            assign prod_q_next[i*3+j] = (2*W)'(a_reg[RA*3+CB]) * (2*W)'(a_reg[RB*3+CA]);
        end
    end

    // top row times first-column cofactors, cofactor split in two halves
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lo_next[j] = CW'(top2_reg[j]) * CW'($signed({1'b0, cof2_reg[j*3][W-1:0]}));
            hi_next[j] = CW'(top2_reg[j]) * CW'($signed(cof2_reg[j*3][2*W:W]));
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DW'(hi_reg[j]) <<< W) + DW'(lo_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            for (int k = 0; k < 9; k++)
            begin
                a_reg[k] <= W'($signed(in_data[k*FIELD_BITS +: MINW]));
            end
            for (int k = 0; k < 3; k++)
            begin
                sh0_reg[k] <= W'($signed(in_data[(9+k)*FIELD_BITS +: MINW]));
            end
        end
        if (load[1])
        begin
            prod_p_reg <= prod_p_next;
            prod_q_reg <= prod_q_next;
            top1_reg   <= a_reg[0:2];
            sh1_reg    <= sh0_reg;
        end
        if (load[2])
        begin
            for (int k = 0; k < 9; k++)
            begin
                cof2_reg[k] <= CW'(prod_p_reg[k]) - CW'(prod_q_reg[k]);
            end
            top2_reg <= top1_reg;
            sh2_reg  <= sh1_reg;
        end
        if (load[3])
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            cof3_reg <= cof2_reg;
            sh3_reg  <= sh2_reg;
        end
        if (load[4])
        begin
            det_reg  <= det_next;
            cof4_reg <= cof3_reg;
            sh4_reg  <= sh3_reg;
        end
    end

    assign cof   = cof4_reg;
    assign det   = det_reg;
    assign shift = sh4_reg;

endmodule

// ===== design/amx_div.sv =====
module amx_div
    import amx_pkg::*;
#(
    parameter int W  = 32,
    parameter int EW = 130
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  beat_ctrl_t          in_ctrl,
    input  logic [EW-1:0]       in_num [3],
    input  logic [EW-1:0]       in_den,
    input  logic [2:0]          in_neg,
    input  logic signed [W-1:0] in_shift,
    output beat_ctrl_t          out_ctrl,
    output logic [W:0]          out_quo [3],
    output logic [2:0]          out_neg,
    output logic signed [W-1:0] out_shift
);

    // one quotient bit per stage, the top bit flags overflow
    localparam int STEPS = W + 1;

    beat_ctrl_t          ctrl_reg  [STEPS+1];
    logic [EW-1:0]       rem_reg   [STEPS+1][3];
    logic [W:0]          quo_reg   [STEPS+1][3];
    logic [EW-1:0]       den_reg   [STEPS+1];
    logic [2:0]          neg_reg   [STEPS+1];
    logic signed [W-1:0] shift_reg [STEPS+1];

    logic [EW-1:0] trial [STEPS][3];
    logic [2:0]    take  [STEPS];

    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[k][l] = rem_reg[k][l] - (den_reg[k] << (W - k));
                take[k][l]  = rem_reg[k][l] >= (den_reg[k] << (W - k));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                ctrl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            ctrl_reg[0] <= in_ctrl;
            for (int k = 0; k < STEPS; k++)
            begin
                ctrl_reg[k+1] <= ctrl_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= in_num;
            den_reg[0]   <= in_den;
            neg_reg[0]   <= in_neg;
            shift_reg[0] <= in_shift;
            for (int l = 0; l < 3; l++)
            begin
                quo_reg[0][l] <= '0;
            end
            for (int k = 0; k < STEPS; k++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[k+1][l] <= take[k][l] ? trial[k][l] : rem_reg[k][l];
                    quo_reg[k+1][l] <= {quo_reg[k][l][W-1:0], take[k][l]};
                end
                den_reg[k+1]   <= den_reg[k];
                neg_reg[k+1]   <= neg_reg[k];
                shift_reg[k+1] <= shift_reg[k];
            end
        end
    end

    assign out_ctrl  = ctrl_reg[STEPS];
    assign out_quo   = quo_reg[STEPS];
    assign out_neg   = neg_reg[STEPS];
    assign out_shift = shift_reg[STEPS];

endmodule

// ===== design/amx_post.sv =====
module amx_post
    import amx_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    output logic                  adv,
    input  beat_ctrl_t            in_ctrl,
    input  logic [W:0]            in_quo [3],
    input  logic [2:0]            in_neg,
    input  logic signed [W-1:0]   in_shift,
    output logic                  out_valid,
    input  logic                  out_ready,
    output slot_t                 out_row,
    output logic [FIELD_BITS-1:0] out_value [3],
    output logic                  out_singular,
    output logic                  out_saturated,
    output logic                  out_last
);

    localparam int AW = 2 * W + 2;
    localparam int NW = 2 * W + 3;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // quotient fix-up stage
    logic signed [W-1:0]   q_val_next [3];
    logic [2:0]            q_clip;
    beat_ctrl_t            q_ctrl_reg;
    logic signed [W-1:0]   q_val_reg [3];
    logic                  q_hit_reg;
    logic signed [W-1:0]   q_shift_reg;
    // translation product stage
    logic signed [2*W-1:0] m_prod_next [3];
    beat_ctrl_t            m_ctrl_reg;
    logic signed [2*W-1:0] m_prod_reg [3];
    logic signed [W-1:0]   m_val_reg [3];
    logic                  m_hit_reg;
    // accumulator and output stage
    logic signed [AW-1:0]  acc_reg [3];
    logic signed [NW-1:0]  neg_sum [3];
    logic signed [NW-1:0]  scaled [3];
    logic [2:0]            fits;
    logic signed [W-1:0]   xl_val [3];
    logic                  o_valid_reg;
    slot_t                 o_row_reg;
    logic [FIELD_BITS-1:0] o_value_reg [3];
    logic                  o_sing_reg;
    logic                  o_sat_reg;
    logic                  o_last_reg;

    assign adv = !o_valid_reg || out_ready;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (in_ctrl.singular)
            begin
                q_clip[l]     = 1'b0;
                q_val_next[l] = '0;
            end
            else if (!in_neg[l])
            begin
                q_clip[l]     = in_quo[l][W] || in_quo[l][W-1];
                q_val_next[l] = q_clip[l] ? MAXV : $signed(in_quo[l][W-1:0]);
            end
            else
            begin
                // magnitude of exactly half the range still fits as the minimum
                q_clip[l]     = in_quo[l][W] ||
                                (in_quo[l][W-1] && (in_quo[l][W-2:0] != '0));
                q_val_next[l] = q_clip[l] ? MINV : $signed(W'(-in_quo[l][W-1:0]));
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            m_prod_next[l] = (2*W)'(q_shift_reg) * (2*W)'(q_val_reg[l]);
        end
    end

    // translation: negate, scale down, clip
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            neg_sum[l] = -NW'(acc_reg[l]);
            scaled[l]  = neg_sum[l] >>> F;
            fits[l]    = (scaled[l][NW-1:W-1] == '0) || (scaled[l][NW-1:W-1] == '1);
            if (fits[l])
            begin
                xl_val[l] = scaled[l][W-1:0];
            end
            else
            begin
                xl_val[l] = scaled[l][NW-1] ? MINV : MAXV;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_ctrl_reg  <= '0;
            m_ctrl_reg  <= '0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            q_ctrl_reg  <= in_ctrl;
            m_ctrl_reg  <= q_ctrl_reg;
            o_valid_reg <= m_ctrl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_val_reg   <= q_val_next;
            q_hit_reg   <= |q_clip;
            q_shift_reg <= in_shift;

            m_prod_reg <= m_prod_next;
            m_val_reg  <= q_val_reg;
            m_hit_reg  <= q_hit_reg;

            if (m_ctrl_reg.valid && (m_ctrl_reg.slot != SLOT_XLATE))
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (m_ctrl_reg.slot == SLOT_ROW0)
                    begin
                        acc_reg[l] <= AW'(m_prod_reg[l]);
                    end
                    else
                    begin
                        acc_reg[l] <= acc_reg[l] + AW'(m_prod_reg[l]);
                    end
                end
            end

            o_row_reg  <= m_ctrl_reg.slot;
            o_sing_reg <= m_ctrl_reg.singular;
            o_last_reg <= (m_ctrl_reg.slot == SLOT_XLATE);
            if (m_ctrl_reg.slot == SLOT_XLATE)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    o_value_reg[l] <= FIELD_BITS'(xl_val[l]);
                end
                o_sat_reg <= !(&fits);
            end
            else
            begin
                for (int l = 0; l < 3; l++)
                begin
                    o_value_reg[l] <= FIELD_BITS'(m_val_reg[l]);
                end
                o_sat_reg <= m_hit_reg;
            end
        end
    end

    assign out_valid     = o_valid_reg;
    assign out_row       = o_row_reg;
    assign out_value     = o_value_reg;
    assign out_singular  = o_sing_reg;
    assign out_saturated = o_sat_reg;
    assign out_last      = o_last_reg;

endmodule

// ===== bench/tb_affine_matrix_inverse_core.sv =====
`timescale 1ns / 100ps

module tb_affine_matrix_inverse_core;
    import amx_pkg::*;

    localparam int FRAC = 16;
    localparam int N_RANDOM = 400;

    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        slot_t       row;
        logic [31:0] value_first;
        logic [31:0] value_second;
        logic [31:0] value_third;
        logic        singular;
        logic        saturated;
        logic        last_row;
    } row_beat_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [USER_BITS-1:0]     m_tuser;
    logic                     m_tlast;

    // matrices waiting to be sent, and inverse rows waiting to come back
    logic [IN_DATA_BITS-1:0] matrix_queue[$];
    row_beat_t               inverse_rows[$];

    int  n_mismatch;
    bit  beat_taken;
    int  burst_left;
    int  gap_left;
    int  cycle_count;
    logic [15:0] ready_mask;

    affine_matrix_inverse_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // clip to a signed 32-bit word, flagging the row when clipped
    function automatic logic [31:0] clip_word(input wide_t v, inout logic hit);
        wide_t hi;
        wide_t lo;
        hi = 32'sh7fffffff;
        lo = -(wide_t'(1) <<< 31);
        if (v > hi)
        begin
            hit = 1'b1;
            return hi[31:0];
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo[31:0];
        end
        return v[31:0];
    endfunction

    // adjugate inverse of one affine matrix, four rows appended to the queue
    task automatic predict_inverse(input logic [IN_DATA_BITS-1:0] d);
        wide_t       el[3][3];
        wide_t       xl[3];
        wide_t       cof[3][3];
        wide_t       det;
        wide_t       acc;
        logic [31:0] inv[3][3];
        logic [31:0] xr[3];
        logic        hit;
        row_beat_t   rb;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                el[i][j] = $signed(d[32*(3*i+j) +: 32]);
            xl[i] = $signed(d[32*(9+i) +: 32]);
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = el[(j+1)%3][(i+1)%3] * el[(j+2)%3][(i+2)%3]
                          - el[(j+1)%3][(i+2)%3] * el[(j+2)%3][(i+1)%3];
        det = el[0][0]*cof[0][0] + el[0][1]*cof[1][0] + el[0][2]*cof[2][0];
        if (det == 0)
        begin
            for (int k = 0; k < 4; k++)
            begin
                rb = '0;
                rb.row      = slot_t'(k);
                rb.singular = 1'b1;
                rb.last_row = (k == 3);
                inverse_rows.push_back(rb);
            end
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            hit = 1'b0;
            for (int j = 0; j < 3; j++)
                inv[i][j] = clip_word((cof[i][j] <<< (2*FRAC)) / det, hit);
            rb = '{slot_t'(i), inv[i][0], inv[i][1], inv[i][2], 1'b0, hit, 1'b0};
            inverse_rows.push_back(rb);
        end
        // translation row from the clipped linear part, floor shift
        hit = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc = acc + xl[k] * wide_t'($signed(inv[k][j]));
            xr[j] = clip_word((-acc) >>> FRAC, hit);
        end
        rb = '{SLOT_XLATE, xr[0], xr[1], xr[2], 1'b0, hit, 1'b1};
        inverse_rows.push_back(rb);
    endtask

    function automatic logic [IN_DATA_BITS-1:0] pack_matrix(input logic [31:0] f[12]);
        logic [IN_DATA_BITS-1:0] d;
        for (int i = 0; i < 12; i++)
            d[32*i +: 32] = f[i];
        return d;
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom;
        return w;
    endfunction

    // signed value in [-lim, lim]
    function automatic logic [31:0] rand_span(input int unsigned lim);
        return 32'($signed($urandom_range(2*lim, 0)) - $signed(lim));
    endfunction

    // source: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || beat_taken)
        begin
            beat_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (matrix_queue.size() > 0)
            begin
                s_tdata  <= matrix_queue.pop_front();
                s_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(12, 1);
                    gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink: stall pattern from a random 16-bit ready mask, sometimes never stalling
    always @(negedge clk)
    begin
        cycle_count++;
        if (cycle_count % 64 == 0)
            ready_mask = ($urandom_range(2, 0) == 0) ? 16'hffff : 16'($urandom);
        m_tready <= ready_mask[cycle_count % 16];
    end

    // accepted matrices feed the prediction
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_inverse(s_tdata);
            beat_taken = 1'b1;
        end
    end

    // result checking
    always @(posedge clk)
    begin
        row_beat_t got;
        row_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[1:0], m_tdata[33:2], m_tdata[65:34], m_tdata[97:66],
                    m_tuser[0], m_tuser[1], m_tlast};
            if (inverse_rows.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected row beat %p", got);
            end
            else
            begin
                want = inverse_rows.pop_front();
                if (got !== want)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("row mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAIL affine_matrix_inverse_core");
        $finish;
    end

    initial
    begin
        logic [31:0] f[12];
        int          kind;
        n_mismatch  = 0;
        beat_taken  = 1'b0;
        burst_left  = 4;
        gap_left    = 0;
        cycle_count = 0;
        ready_mask  = 16'hffff;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // identity, translated
        f = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000,
              32'h30000, 32'hfffe0000, 32'h8000};
        matrix_queue.push_back(pack_matrix(f));
        // all zero, singular
        f = '{default: 32'h0};
        matrix_queue.push_back(pack_matrix(f));
        // all largest, all smallest: equal rows so singular
        f = '{default: 32'h7fffffff};
        matrix_queue.push_back(pack_matrix(f));
        f = '{default: 32'h80000000};
        matrix_queue.push_back(pack_matrix(f));
        // tiny diagonal, inverse clips high, translation clips too
        f = '{32'h1, 0, 0, 0, 32'h1, 0, 0, 0, 32'h1,
              32'h7fffffff, 32'h80000000, 32'h1};
        matrix_queue.push_back(pack_matrix(f));
        // tiny negative diagonal, inverse clips low
        f = '{32'hffffffff, 0, 0, 0, 32'hffffffff, 0, 0, 0, 32'h1,
              32'h80000000, 32'h7fffffff, 32'hffffffff};
        matrix_queue.push_back(pack_matrix(f));
        // huge diagonal, inverse nearly zero
        f = '{32'h7fffffff, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h80000000};
        matrix_queue.push_back(pack_matrix(f));
        // scale by two with odd translation, floor rounding of negatives
        f = '{32'h20000, 0, 0, 0, 32'h20000, 0, 0, 0, 32'h20000,
              32'h1, 32'hffffffff, 32'h3};
        matrix_queue.push_back(pack_matrix(f));
        // permutation with a sign flip
        f = '{0, 32'h10000, 0, 32'hffff0000, 0, 0, 0, 0, 32'h10000,
              32'h12345, 32'hfedcb, 32'h0};
        matrix_queue.push_back(pack_matrix(f));
        // linearly dependent rows with translation, singular
        f = '{32'h10000, 32'h20000, 32'h30000, 32'h20000, 32'h40000, 32'h60000,
              32'h5, 32'h7, 32'h9, 32'h11111, 32'h22222, 32'h33333};
        matrix_queue.push_back(pack_matrix(f));
        // full random content
        for (int n = 0; n < 6; n++)
        begin
            foreach (f[i])
                f[i] = rand_word();
            matrix_queue.push_back(pack_matrix(f));
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            kind = $urandom_range(9, 0);
            foreach (f[i])
                f[i] = rand_word();
            if (kind < 6)
            begin
                // well conditioned: moderate entries with a strong diagonal
                for (int i = 0; i < 9; i++)
                    f[i] = rand_span(32'h20000);
                for (int i = 0; i < 3; i++)
                    f[4*i] = f[4*i] + (($urandom_range(1, 0) == 1) ? 32'h40000 : 32'hfffc0000);
                for (int i = 9; i < 12; i++)
                    f[i] = ($urandom_range(3, 0) == 0) ? rand_word() : rand_span(32'h1000000);
            end
            else if (kind == 6)
            begin
                // small entries: large inverse, clipping likely
                for (int i = 0; i < 9; i++)
                    f[i] = rand_span(64);
            end
            else if (kind == 7)
            begin
                // repeated row, singular
                for (int j = 0; j < 3; j++)
                    f[6+j] = f[3*($urandom_range(1, 0))+j];
            end
            matrix_queue.push_back(pack_matrix(f));
        end

        // the last matrix is driven in the same step as the pop, so let it settle first
        wait (matrix_queue.size() == 0);
        @(negedge clk);
        wait (!s_tvalid);
        wait (inverse_rows.size() == 0);
        repeat (60) @(posedge clk);
        if (n_mismatch == 0 && inverse_rows.size() == 0)
            $display("PASS affine_matrix_inverse_core");
        else
            $display("FAIL affine_matrix_inverse_core");
        $finish;
    end

endmodule
